[rtl/core/xxtea_pkg.sv]
// package: sizes, constants, state type and mixing function of the xxtea encryptor
package xxtea_pkg;

   localparam int WORDS     = 8;
   localparam int IDX_W     = $clog2(WORDS);
   localparam int ROUNDS    = 6 + 52 / WORDS;
   localparam int ROUND_W   = $clog2(ROUNDS);
   localparam int KEY_WORDS = 4;
   localparam int CSR_IDX_W = 8;

   localparam logic [31:0] DELTA = 32'h9E3779B9;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_3 = CSR_IDX_W'(3);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PRIME0,
      ST_PRIME1,
      ST_ENC,
      ST_OUT_RD,
      ST_OUT_WR
   } state_type;

   function automatic logic [31:0] xxtea_mix(
      input logic [31:0] z,
      input logic [31:0] y,
      input logic [31:0] sum,
      input logic [31:0] k
   );
      logic [31:0] t1;
      logic [31:0] t2;
      t1 = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      t2 = (sum ^ y) + (k ^ z);
      return t1 ^ t2;
   endfunction

endpackage

[rtl/core/xxtea_ram.sv]
// generic single-write, single-read ram with registered read data
module xxtea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/xxtea_block_encrypt_top.sv]
// top level: xxtea block encryptor with block store in ram and key registers
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | req_tdata = plain_word
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata = cipher_word, rsp_tlast = final_word
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data (key words 0..3)
//
// one word loads per cycle while req_tvalid is high; after the last word the states
// ST_PRIME0 and ST_PRIME1 prime the ram read, then WORDS*ROUNDS word updates run,
// one per cycle, bound by the z recurrence through the ram read port, then each
// ciphertext word passes ST_OUT_RD and ST_OUT_WR for the registered read.
// synchronous reset sets key words to all ones and idles the block; the ram is not cleared.
// a stalled rsp holds the block in the drain; req is taken only while loading.
module xxtea_block_encrypt_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [31:0] plain_word
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [31:0] cipher_word
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [xxtea_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data
);
   import xxtea_pkg::*;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]   load_ff, load_in;
   logic [IDX_W-1:0]   p_ff, p_in;
   logic [IDX_W-1:0]   out_ff, out_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        z_ff, z_in;
   logic [31:0]        x_ff, x_in;
   logic               fwd_ff;
   logic [31:0]        fwd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [31:0]        key_ff [KEY_WORDS];

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      ram_q;

   logic             req_accept;
   logic             rsp_free;
   logic             load_last;
   logic             p_last;
   logic             round_last;
   logic             out_last;
   logic [31:0]      y;
   logic [31:0]      z_new;
   logic [1:0]       e;
   logic [31:0]      key_sel;
   logic [IDX_W:0]   p_plus2;
   logic [IDX_W-1:0] nxt2;

   xxtea_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign load_last  = (load_ff == IDX_W'(WORDS - 1));
   assign p_last     = (p_ff == IDX_W'(WORDS - 1));
   assign round_last = (round_ff == ROUND_W'(ROUNDS - 1));
   assign out_last   = (out_ff == IDX_W'(WORDS - 1));

   // read data, bypassed when the same entry was written in the read cycle
   assign y       = fwd_ff ? fwd_data_ff : ram_q;
   assign e       = sum_ff[3:2];
   assign key_sel = key_ff[2'(p_ff) ^ e];
   assign z_new   = x_ff + xxtea_mix(z_ff, y, sum_ff, key_sel);

   assign p_plus2 = {1'b0, p_ff} + (IDX_W + 1)'(2);
   assign nxt2    = (p_plus2 >= (IDX_W + 1)'(WORDS)) ?
                    IDX_W'(p_plus2 - (IDX_W + 1)'(WORDS)) : IDX_W'(p_plus2);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && load_last) begin
               state_in = ST_PRIME0;
            end
         end
         ST_PRIME0: state_in = ST_PRIME1;
         ST_PRIME1: state_in = ST_ENC;
         ST_ENC: begin
            if (p_last && round_last) begin
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_WR;
         ST_OUT_WR: begin
            if (rsp_free) begin
               state_in = out_last ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      load_in      = load_ff;
      p_in         = p_ff;
      out_in       = out_ff;
      round_in     = round_ff;
      sum_in       = sum_ff;
      z_in         = z_ff;
      x_in         = x_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = p_ff;
      wr_data      = z_new;
      rd_addr      = out_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_accept) begin
               wr_en   = 1'b1;
               wr_addr = load_ff;
               wr_data = req_tdata;
               if (load_last) begin
                  load_in = '0;
                  z_in    = req_tdata;
               end else begin
                  load_in = load_ff + IDX_W'(1);
               end
            end
         end
         ST_PRIME0: begin
            rd_addr = '0;
         end
         ST_PRIME1: begin
            rd_addr  = IDX_W'(1);
            x_in     = y;
            sum_in   = DELTA;
            p_in     = '0;
            round_in = '0;
         end
         ST_ENC: begin
            wr_en   = 1'b1;
            wr_addr = p_ff;
            wr_data = z_new;
            rd_addr = nxt2;
            x_in    = y;
            z_in    = z_new;
            out_in  = '0;
            if (p_last) begin
               p_in     = '0;
               round_in = ROUND_W'(round_ff + ROUND_W'(1));
               sum_in   = sum_ff + DELTA;
            end else begin
               p_in = p_ff + IDX_W'(1);
            end
         end
         ST_OUT_RD: begin
            rd_addr = out_ff;
         end
         ST_OUT_WR: begin
            rd_addr = out_ff;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y;
               rsp_last_in  = out_last;
               out_in       = out_last ? '0 : out_ff + IDX_W'(1);
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_ff      <= '0;
         p_ff         <= '0;
         out_ff       <= '0;
         round_ff     <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         p_ff         <= p_in;
         out_ff       <= out_in;
         round_ff     <= round_in;
         fwd_ff       <= wr_en && (wr_addr == rd_addr);
         rsp_valid_ff <= rsp_valid_in;
      end
      fwd_data_ff <= wr_data;
      sum_ff      <= sum_in;
      z_ff        <= z_in;
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '1;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_0: key_ff[0] <= csr_data;
            CSR_KEY_1: key_ff[1] <= csr_data;
            CSR_KEY_2: key_ff[2] <= csr_data;
            CSR_KEY_3: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/core/xxtea_chk.sv]
// checker: port-level assertions for the xxtea encryptor, bound to the top level
module xxtea_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // after reset the block is empty and ready to load
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a stalled transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp transaction changed");

   // no loading while a block is still draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("req taken during block drain");

endmodule

bind xxtea_block_encrypt_top xxtea_chk u_xxtea_chk (.*);
